>>> sv/tps_pkg.sv
// Shared types and constants for the thin-plate spline kernel.
package tps_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int THRESH_WIDTH = 24;
  localparam int BIG_SHIFT    = 26;
  localparam int SQ_WIDTH     = 2 * BIG_SHIFT;
  localparam int SUM_WIDTH    = SQ_WIDTH + 2;
  localparam int NORM_WIDTH   = 64;
  localparam int EXP_WIDTH    = 6;
  localparam int FRAC_BITS    = 32;
  localparam int MANT_WIDTH   = 62;
  localparam int LOG_ROUNDS   = 32;
  localparam int LG_WIDTH     = EXP_WIDTH + FRAC_BITS;
  localparam int MAG_WIDTH    = 37;
  localparam int RES_WIDTH    = 50;
  localparam int OUT_WIDTH    = 48;
  localparam int BIAS_EXP     = 24;
  localparam int SCALE_SHIFT  = 41;
  localparam int PADDR_WIDTH  = 3;
  localparam int PDATA_WIDTH  = 32;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_NONE      = 1'b1
  } tps_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
  } tps_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] basis_value;
    logic                        below_threshold;
  } tps_out_t;

  // side info that rides along the log chain
  typedef struct packed {
    logic                 big;
    logic                 below;
    logic [SUM_WIDTH-1:0] s;
    logic [EXP_WIDTH-1:0] k;
  } tps_ctx_t;

endpackage

>>> sv/tps_front.sv
// Front end: differences, squared distance, threshold test, normalization.
module tps_front import tps_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  tps_in_t                        in_word,
  input  logic [THRESH_WIDTH-1:0]        thresh,
  output logic                           out_valid,
  output tps_ctx_t                       out_ctx,
  output logic [MANT_WIDTH-1:0]          out_x
);

  function automatic logic [COORD_WIDTH:0] abs_diff(
    input logic signed [COORD_WIDTH-1:0] p,
    input logic signed [COORD_WIDTH-1:0] c
  );
    logic signed [COORD_WIDTH:0] d;
    d = (COORD_WIDTH+1)'(p) - (COORD_WIDTH+1)'(c);
    return d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d) : (COORD_WIDTH+1)'(d);
  endfunction

  logic [COORD_WIDTH:0] ax, ay, az;
  logic                 big_nxt;

  // stage 1
  logic                 v1_r;
  logic                 big1_r;
  logic [BIG_SHIFT-1:0] ax_r, ay_r, az_r;
  // stage 2
  logic                     v2_r;
  logic                     big2_r;
  logic [SQ_WIDTH-1:0]      sqx_r, sqy_r, sqz_r;
  logic [2*THRESH_WIDTH-1:0] tsq_r;
  // stage 3 and normalizer, index 0 is stage 3
  logic [SUM_WIDTH-1:0]  sum_nxt;
  logic [3:0]            nval_r;
  logic                  nbig_r   [0:3];
  logic                  nbelow_r [0:3];
  logic [SUM_WIDTH-1:0]  ns_r     [0:3];
  logic [NORM_WIDTH-1:0] nv_r     [0:3];
  logic [EXP_WIDTH-1:0]  nc_r     [0:3];

  assign ax = abs_diff(in_word.point_x, in_word.center_x);
  assign ay = abs_diff(in_word.point_y, in_word.center_y);
  assign az = abs_diff(in_word.point_z, in_word.center_z);
  assign big_nxt = ((ax >> BIG_SHIFT) != '0) || ((ay >> BIG_SHIFT) != '0) ||
                   ((az >> BIG_SHIFT) != '0);
  assign sum_nxt = SUM_WIDTH'(sqx_r) + SUM_WIDTH'(sqy_r) + SUM_WIDTH'(sqz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      nval_r <= '0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      nval_r[0] <= v2_r;
      nval_r[3:1] <= nval_r[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big1_r <= big_nxt;
      ax_r   <= BIG_SHIFT'(ax);
      ay_r   <= BIG_SHIFT'(ay);
      az_r   <= BIG_SHIFT'(az);
      big2_r <= big1_r;
      sqx_r  <= ax_r * ax_r;
      sqy_r  <= ay_r * ay_r;
      sqz_r  <= az_r * az_r;
      tsq_r  <= thresh * thresh;
      nbig_r[0]   <= big2_r;
      nbelow_r[0] <= sum_nxt <= SUM_WIDTH'(tsq_r);
      ns_r[0]     <= sum_nxt;
      nv_r[0]     <= NORM_WIDTH'(sum_nxt);
      nc_r[0]     <= '0;
    end
  end

  // leading-one search, two shift steps per stage
  for (genvar g = 0; g < 3; g++) begin : g_norm
    localparam int SHA = 32 >> (2 * g);
    localparam int SHB = SHA / 2;
    logic [NORM_WIDTH-1:0] va;
    logic [EXP_WIDTH-1:0]  ca;

    always_comb begin
      va = nv_r[g];
      ca = nc_r[g];
      if (va[NORM_WIDTH-1 -: SHA] == '0) begin
        va = va << SHA;
        ca = ca + EXP_WIDTH'(SHA);
      end
      if (va[NORM_WIDTH-1 -: SHB] == '0) begin
        va = va << SHB;
        ca = ca + EXP_WIDTH'(SHB);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nbig_r[g+1]   <= nbig_r[g];
        nbelow_r[g+1] <= nbelow_r[g];
        ns_r[g+1]     <= ns_r[g];
        nv_r[g+1]     <= va;
        nc_r[g+1]     <= ca;
      end
    end
  end

  assign out_valid     = nval_r[3];
  assign out_ctx.big   = nbig_r[3];
  assign out_ctx.below = nbelow_r[3];
  assign out_ctx.s     = ns_r[3];
  assign out_ctx.k     = EXP_WIDTH'(NORM_WIDTH - 1) - nc_r[3];
  assign out_x         = nv_r[3][NORM_WIDTH-1:NORM_WIDTH-MANT_WIDTH];

endmodule

>>> sv/tps_log_cell.sv
// One squaring round of the log2 fraction: product stage, then sum and bit.
module tps_log_cell import tps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  tps_ctx_t              in_ctx,
  input  logic [MANT_WIDTH-1:0] in_x,
  input  logic [FRAC_BITS-1:0]  in_frac,
  output logic                  out_valid,
  output tps_ctx_t              out_ctx,
  output logic [MANT_WIDTH-1:0] out_x,
  output logic [FRAC_BITS-1:0]  out_frac
);

  localparam int HI_WIDTH = MANT_WIDTH - 32;
  localparam int SQ_FULL  = 2 * MANT_WIDTH;

  logic [HI_WIDTH-1:0]   hi;
  logic [31:0]           lo;
  logic                  va_r;
  tps_ctx_t              ctx_a_r;
  logic [FRAC_BITS-1:0]  frac_a_r;
  logic [2*HI_WIDTH-1:0] phh_r;
  logic [HI_WIDTH+31:0]  phl_r;
  logic [63:0]           pll_r;
  logic [SQ_FULL-1:0]    sq;
  logic [MANT_WIDTH:0]   sqt;
  logic                  vb_r;
  tps_ctx_t              ctx_b_r;
  logic [MANT_WIDTH-1:0] x_b_r;
  logic [FRAC_BITS-1:0]  frac_b_r;

  assign hi = in_x[MANT_WIDTH-1:32];
  assign lo = in_x[31:0];

  // x*x truncated to Q2.61
  assign sq  = {phh_r, 64'd0} + SQ_FULL'({phl_r, 33'd0}) + SQ_FULL'(pll_r);
  assign sqt = sq[SQ_FULL-1:61];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a_r  <= in_ctx;
      frac_a_r <= in_frac;
      phh_r    <= hi * hi;
      phl_r    <= hi * lo;
      pll_r    <= lo * lo;
      ctx_b_r  <= ctx_a_r;
      if (sqt[MANT_WIDTH]) begin
        x_b_r    <= sqt[MANT_WIDTH:1];
        frac_b_r <= {frac_a_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        x_b_r    <= sqt[MANT_WIDTH-1:0];
        frac_b_r <= {frac_a_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vb_r;
  assign out_ctx   = ctx_b_r;
  assign out_x     = x_b_r;
  assign out_frac  = frac_b_r;

endmodule

>>> sv/tps_back.sv
// Back end: ln scaling, r^2*ln(r) product, saturation, output register.
module tps_back import tps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  tps_ctx_t             in_ctx,
  input  logic [FRAC_BITS-1:0] in_frac,
  output logic                 out_valid,
  output tps_out_t             out_word
);

  localparam logic [LG_WIDTH-1:0] BIAS_LG = LG_WIDTH'(BIAS_EXP) << FRAC_BITS;
  localparam int WH = MAG_WIDTH - 32;
  localparam int SH = SUM_WIDTH - 32;
  localparam int FULL_WIDTH = SUM_WIDTH + MAG_WIDTH;

  logic [LG_WIDTH-1:0]  lg;
  logic                 neg_nxt;
  logic [LG_WIDTH-1:0]  mag_nxt;

  logic [5:0]           v_r;
  tps_ctx_t             c_m_r, c_w1_r, c_w2_r, c_r1_r, c_r2_r;
  logic                 n_m_r, n_w1_r, n_w2_r, n_r1_r, n_r2_r;
  logic [MAG_WIDTH-1:0] mag_r;
  logic [MAG_WIDTH-1:0] p1_r;
  logic [63:0]          p0_r;
  logic [MAG_WIDTH-1:0] w_r;
  logic [63:0]          q_ll_r;
  logic [WH+31:0]       q_lh_r;
  logic [SH+31:0]       q_hl_r;
  logic [SH+WH-1:0]     q_hh_r;
  logic [FULL_WIDTH-1:0] full;
  logic [RES_WIDTH-1:0] res_r;
  logic [OUT_WIDTH-1:0] sat;
  tps_out_t             word_nxt;
  tps_out_t             out_r;

  assign lg      = {in_ctx.k, in_frac};
  assign neg_nxt = in_ctx.k < EXP_WIDTH'(BIAS_EXP);
  assign mag_nxt = neg_nxt ? (BIAS_LG - lg) : (lg - BIAS_LG);

  assign full = FULL_WIDTH'(q_ll_r) + (FULL_WIDTH'(q_lh_r) << 32) +
                (FULL_WIDTH'(q_hl_r) << 32) + (FULL_WIDTH'(q_hh_r) << 64);

  always_comb begin
    sat = (res_r > RES_WIDTH'(OUT_MAX)) ? OUT_MAX : res_r[OUT_WIDTH-1:0];
    if (c_r2_r.big) begin
      word_nxt.basis_value     = OUT_MAX;
      word_nxt.below_threshold = 1'b0;
    end else if (c_r2_r.below) begin
      word_nxt.basis_value     = '0;
      word_nxt.below_threshold = 1'b1;
    end else begin
      word_nxt.basis_value     = n_r2_r ? -sat : sat;
      word_nxt.below_threshold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_m_r  <= in_ctx;
      n_m_r  <= neg_nxt;
      mag_r  <= MAG_WIDTH'(mag_nxt);
      c_w1_r <= c_m_r;
      n_w1_r <= n_m_r;
      p1_r   <= mag_r[MAG_WIDTH-1:32] * LN2_Q32;
      p0_r   <= mag_r[31:0] * LN2_Q32;
      c_w2_r <= c_w1_r;
      n_w2_r <= n_w1_r;
      w_r    <= MAG_WIDTH'(p1_r + MAG_WIDTH'(p0_r[63:32]));
      c_r1_r <= c_w2_r;
      n_r1_r <= n_w2_r;
      q_ll_r <= c_w2_r.s[31:0] * w_r[31:0];
      q_lh_r <= c_w2_r.s[31:0] * w_r[MAG_WIDTH-1:32];
      q_hl_r <= c_w2_r.s[SUM_WIDTH-1:32] * w_r[31:0];
      q_hh_r <= c_w2_r.s[SUM_WIDTH-1:32] * w_r[MAG_WIDTH-1:32];
      c_r2_r <= c_r1_r;
      n_r2_r <= n_r1_r;
      res_r  <= full[FULL_WIDTH-1:SCALE_SHIFT];
      out_r  <= word_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign out_word  = out_r;

endmodule

>>> sv/thin_plate_spline_kernel.sv
// Thin-plate spline kernel top: front and back ends, log2 cell chain, APB register.
//
// Usage:
//   Input channel in_valid/in_ready/in_word carries one word per point pair:
//   point and control point, signed Q12.12 coordinates. The result channel
//   out_valid/out_ready/out_word returns r*r*ln(r) in signed Q31.16 plus a
//   flag that is set when r is at or below distance_threshold (result 0).
//   Distances with a coordinate difference of 2^26 or more saturate.
//   The APB port holds distance_threshold at byte address 0; write it only
//   while no word is in flight.
// Order: differencing, squaring and summing, then normalization, then 32
//   log cells of a product stage and a sum stage each, then ln scaling,
//   final product and the output register.
// Throughput: one word per cycle; the whole pipeline advances together.
// Stall: when out_valid is high and out_ready low, every stage holds and
//   in_ready drops in the same cycle; nothing is lost.
// Reset: rst_n low clears all valid bits and the threshold to zero, and
//   holds in_ready low.
//
module thin_plate_spline_kernel import tps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tps_in_t                in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tps_out_t               out_word,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready
);

  logic [THRESH_WIDTH-1:0] thresh_r;
  logic                    wr_en;
  tps_reg_t                reg_sel;
  logic                    en;

  // log chain wiring, index 0 fed by the front end
  logic                  cv    [0:LOG_ROUNDS];
  tps_ctx_t              cctx  [0:LOG_ROUNDS];
  logic [MANT_WIDTH-1:0] cx    [0:LOG_ROUNDS];
  logic [FRAC_BITS-1:0]  cfrac [0:LOG_ROUNDS];

  // register port: word index is paddr[2]
  assign pready  = 1'b1;
  assign reg_sel = tps_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign prdata  = (reg_sel == REG_THRESHOLD) ? PDATA_WIDTH'(thresh_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (wr_en && (reg_sel == REG_THRESHOLD)) begin
      thresh_r <= pwdata[THRESH_WIDTH-1:0];
    end
  end

  // global advance: output register empty or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en && rst_n;

  tps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .thresh    (thresh_r),
    .out_valid (cv[0]),
    .out_ctx   (cctx[0]),
    .out_x     (cx[0])
  );

  assign cfrac[0] = '0;

  // one fraction bit of log2 per cell
  for (genvar i = 0; i < LOG_ROUNDS; i++) begin : g_cell
    tps_log_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[i]),
      .in_ctx    (cctx[i]),
      .in_x      (cx[i]),
      .in_frac   (cfrac[i]),
      .out_valid (cv[i+1]),
      .out_ctx   (cctx[i+1]),
      .out_x     (cx[i+1]),
      .out_frac  (cfrac[i+1])
    );
  end

  tps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cv[LOG_ROUNDS]),
    .in_ctx    (cctx[LOG_ROUNDS]),
    .in_frac   (cfrac[LOG_ROUNDS]),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.below_threshold |-> out_word.basis_value == '0)
    else $error("below-threshold word with nonzero value");

  a_neg_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.basis_value[OUT_WIDTH-1] |->
      out_word.basis_value > -48'sd65536)
    else $error("negative result below -1.0");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output changed during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the thin-plate spline kernel.
module testbench;
  import tps_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int PIPE_LATENCY  = 76;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int N_RANDOM      = 930;
  localparam int IN_BITS       = 6 * COORD_WIDTH;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  tps_in_t                in_word;
  logic                   out_valid;
  logic                   out_ready;
  tps_out_t               out_word;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [PDATA_WIDTH-1:0] pwdata;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  // model copy of distance_threshold
  logic [THRESH_WIDTH-1:0] thresh_q;
  // expected basis values, oldest first
  tps_out_t                basis_q[$];
  int                      err_count;
  int                      cycle_count;
  int                      send_idle_pct;
  int                      recv_idle_pct;

  thin_plate_spline_kernel u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // floor(a*b / 2^sh), low 64 bits
  function automatic longint unsigned mul_shr(longint unsigned a, longint unsigned b, int sh);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> sh;
    return prod[63:0];
  endfunction

  // log2 with 32 fraction bits: leading-one index plus squaring rounds
  function automatic longint unsigned log2_fix(longint unsigned s);
    int              k;
    longint unsigned x;
    longint unsigned frac;
    k = 0;
    frac = 0;
    while (k < 63 && (s >> (k + 1)) != 0) k++;
    x = s << (61 - k);
    for (int i = 0; i < LOG_ROUNDS; i++) begin
      x = mul_shr(x, x, 61);
      frac = frac << 1;
      if (x >= (64'd1 << 62)) begin
        frac = frac | 64'd1;
        x = x >> 1;
      end
    end
    return (longint'(k) << 32) | frac;
  endfunction

  function automatic longint unsigned abs_delta(logic signed [COORD_WIDTH-1:0] p,
                                                logic signed [COORD_WIDTH-1:0] c);
    longint d;
    d = longint'(p) - longint'(c);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  // r*r*ln(r) in Q31.16 for one point pair under the given threshold
  function automatic tps_out_t predict_basis(tps_in_t w, logic [THRESH_WIDTH-1:0] thr);
    tps_out_t        r;
    longint unsigned dx, dy, dz, s, lg, mag, wl, res, bias, t;
    logic            neg;
    dx = abs_delta(w.point_x, w.center_x);
    dy = abs_delta(w.point_y, w.center_y);
    dz = abs_delta(w.point_z, w.center_z);
    bias = longint'(BIAS_EXP) << 32;
    t = thr;
    r.below_threshold = 1'b0;
    if (dx >= (64'd1 << BIG_SHIFT) || dy >= (64'd1 << BIG_SHIFT) ||
        dz >= (64'd1 << BIG_SHIFT)) begin
      r.basis_value = OUT_MAX;
      return r;
    end
    s = dx * dx + dy * dy + dz * dz;
    if (s <= t * t) begin
      r.basis_value = '0;
      r.below_threshold = 1'b1;
      return r;
    end
    lg = log2_fix(s);
    neg = (lg < bias);
    mag = neg ? bias - lg : lg - bias;
    wl = mul_shr(mag, longint'(LN2_Q32), 32);
    res = mul_shr(s, wl, SCALE_SHIFT);
    if (res > longint'(OUT_MAX)) res = OUT_MAX;
    if (neg) res = -res;
    r.basis_value = res[OUT_WIDTH-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    tps_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (basis_q.size() == 0) begin
        report_mismatch("unexpected word", out_word.basis_value, 0);
      end else begin
        want = basis_q.pop_front();
        if (out_word.basis_value !== want.basis_value)
          report_mismatch("basis_value", out_word.basis_value, want.basis_value);
        if (out_word.below_threshold !== want.below_threshold)
          report_mismatch("below_threshold", out_word.below_threshold,
                          want.below_threshold);
      end
    end
  end

  // receiver stalls at the current rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d, %0d words outstanding", cycle_count, basis_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // send one word; valid stays up across back-to-back words
  task automatic send_pair(tps_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    basis_q.push_back(predict_basis(w, thresh_q));
  endtask

  // wait for every expected word, then let the pipe empty out
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(tps_reg_t idx, logic [PDATA_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_WIDTH'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_THRESHOLD) thresh_q = value[THRESH_WIDTH-1:0];
  endtask

  function automatic tps_in_t make_pair(logic signed [COORD_WIDTH-1:0] dx,
                                        logic signed [COORD_WIDTH-1:0] dy,
                                        logic signed [COORD_WIDTH-1:0] dz);
    tps_in_t w;
    w.center_x = COORD_WIDTH'($urandom_range(2000) - 1000);
    w.center_y = COORD_WIDTH'($urandom_range(2000) - 1000);
    w.center_z = COORD_WIDTH'($urandom_range(2000) - 1000);
    w.point_x  = w.center_x + dx;
    w.point_y  = w.center_y + dy;
    w.point_z  = w.center_z + dz;
    return w;
  endfunction

  // random pair: mostly close by (small r, negative values, threshold region)
  function automatic tps_in_t rand_pair();
    tps_in_t w;
    int      sh;
    w = tps_in_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(99) < 70) begin
      sh = $urandom_range(18);
      w.point_x = COORD_WIDTH'(w.center_x +
                               (($urandom & ((1 << sh) - 1)) - (1 << (sh - 1))));
      w.point_y = COORD_WIDTH'(w.center_y +
                               (($urandom & ((1 << sh) - 1)) - (1 << (sh - 1))));
      w.point_z = COORD_WIDTH'(w.center_z +
                               (($urandom & ((1 << sh) - 1)) - (1 << (sh - 1))));
    end
    return w;
  endfunction

  // field extremes, zero and unit distance, sub-unit distances
  task automatic test_directed();
    tps_in_t w;
    apb_write(REG_THRESHOLD, 0);
    send_pair('0);                                  // r = 0 with zero threshold
    w = '0;
    w.point_x = 24'sh7FFFFF; w.point_y = 24'sh7FFFFF; w.point_z = 24'sh7FFFFF;
    w.center_x = 24'sh800000; w.center_y = 24'sh800000; w.center_z = 24'sh800000;
    send_pair(w);                                   // farthest possible pair
    send_pair(tps_in_t'({w.center_x, w.center_y, w.center_z,
                         w.point_x, w.point_y, w.point_z}));
    send_pair(make_pair(24'sd4096, 0, 0));          // r = 1 -> zero, not flagged
    send_pair(make_pair(0, 0, 24'sd1));             // smallest nonzero r
    send_pair(make_pair(24'sd2048, 0, 0));          // r = 0.5, negative value
    send_pair(make_pair(24'sd2484, 0, 0));          // near 1/sqrt(e), most negative
    send_pair(make_pair(-24'sd11134, 0, 0));        // about e
    send_pair(make_pair(24'sd4096, -24'sd4096, 24'sd4096));
    w = '1;
    send_pair(w);
    drain_pipe();
  endtask

  // threshold boundaries, the maximum, and the unmapped register
  task automatic test_threshold();
    apb_write(REG_THRESHOLD, 32'd4096);
    send_pair(make_pair(24'sd4096, 0, 0));          // r equal to threshold
    send_pair(make_pair(24'sd4097, 0, 0));          // just above
    send_pair(make_pair(0, 24'sd4095, 0));
    send_pair(make_pair(24'sd2896, 24'sd2896, 0));
    drain_pipe();
    apb_write(REG_NONE, 32'hFFFF_FFFF);             // must be ignored
    send_pair(make_pair(24'sd4096, 0, 0));
    send_pair(make_pair(24'sd4097, 0, 0));
    drain_pipe();
    apb_write(REG_THRESHOLD, 32'h00FF_FFFF);
    send_pair(make_pair(24'sh7FFFFF, 0, 0));
    send_pair(make_pair(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
    drain_pipe();
  endtask

  task automatic test_random(int n, int s_idle, int r_idle, logic [THRESH_WIDTH-1:0] thr);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    apb_write(REG_THRESHOLD, PDATA_WIDTH'(thr));
    for (int i = 0; i < n; i++) begin
      send_pair(rand_pair());
      // one mid-phase hold-off until the pipe is empty
      if (i == n / 2) begin
        in_valid <= 1'b0;
        while (basis_q.size() != 0) @(posedge clk);
      end
    end
    drain_pipe();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    thresh_q      = '0;
    err_count     = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_threshold();
    test_random(N_RANDOM / 3, 23, 87, 24'd0);
    test_random(N_RANDOM / 3, 87, 23, THRESH_WIDTH'($urandom_range(8192)));
    test_random(N_RANDOM / 3, 0, 0, THRESH_WIDTH'($urandom_range(1024)));

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
